>>> hdl/pls_pkg.sv
// pls_pkg: request, status and cell-control types for the positional list store.
// No dependencies; imported by every module of the block.
`default_nettype none

package pls_pkg;

    typedef enum logic [2:0] {
        REQ_INS_FRONT = 3'd0,
        REQ_INS_END   = 3'd1,
        REQ_INS_POS   = 3'd2,
        REQ_DEL_FRONT = 3'd3,
        REQ_DEL_END   = 3'd4,
        REQ_DEL_POS   = 3'd5
    } t_req;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_BEYOND  = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2
    } t_cell_op;

    typedef struct packed {
        t_cell_op    op;
        logic [31:0] word;
    } t_cell_ctl;

    localparam int WORD_W  = 32;
    localparam int COUNT_W = 5;

endpackage

`default_nettype wire

>>> hdl/pls_cell.sv
// pls_cell: one entry of the shifting chain; takes its left neighbor on insert,
// its right neighbor on delete, or the new word at the insert point. Uses pls_pkg.
`default_nettype none

module pls_cell
    import pls_pkg::*;
#(
    parameter int IDX = 0,
    parameter int AW  = 5
) (
    input  wire logic              i_clk,
    input  wire t_cell_ctl         i_ctl,
    input  wire logic [AW-1:0]     i_at,
    input  wire logic [WORD_W-1:0] i_left,
    input  wire logic [WORD_W-1:0] i_right,
    output logic      [WORD_W-1:0] o_word
);

    localparam logic [AW-1:0] MY_IDX = AW'(IDX);

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;

    always_comb begin
        n_word = r_word;
        case (i_ctl.op)
            CELL_INSERT: begin
                if (MY_IDX == i_at) begin
                    n_word = i_ctl.word;
                end else if (MY_IDX > i_at) begin
                    n_word = i_left;
                end
            end
            CELL_DELETE: begin
                if (MY_IDX >= i_at) begin
                    n_word = i_right;
                end
            end
            default: n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

>>> hdl/pls_ctrl.sv
// pls_ctrl: request decode, entry count, handshakes and result register.
// Drives the cell chain of the list store; uses pls_pkg.
`default_nettype none

module pls_ctrl
    import pls_pkg::*;
#(
    parameter int LIST_DEPTH = 16,
    parameter int CW         = 5
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic [2:0]               i_req_type,
    input  wire logic [WORD_W-1:0]        i_item_value,
    input  wire logic [7:0]               i_position,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic [2:0]                    o_status,
    output logic [WORD_W-1:0]             o_removed_value,
    output logic [COUNT_W-1:0]            o_entry_count,
    input  wire logic [WORD_W-1:0]        i_cell_word [LIST_DEPTH],
    output t_cell_ctl                     o_cell_ctl,
    output logic [CW-1:0]                 o_at
);

    localparam int            WW   = (CW > 8) ? CW : 8;
    localparam logic [CW-1:0] FULL = CW'(LIST_DEPTH);

    logic              r_busy;
    logic [2:0]        r_type;
    logic [WORD_W-1:0] r_word;
    logic [7:0]        r_pos;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              r_out_valid;
    logic [2:0]        r_status;
    logic [WORD_W-1:0] r_removed;
    logic [COUNT_W-1:0] r_ecount;

    logic              exec;
    t_status           status;
    t_cell_op          op;
    logic [CW-1:0]     at;
    logic [WW-1:0]     pos_w;
    logic [WW-1:0]     cnt_w;
    logic [WW-1:0]     pos_m1;
    logic [WORD_W-1:0] picked;
    logic [CW+COUNT_W-1:0] count_ext;

    assign exec       = r_busy && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_busy;

    assign pos_w  = WW'(r_pos);
    assign cnt_w  = WW'(r_count);
    assign pos_m1 = pos_w - WW'(1);

    always_comb begin
        status = ST_OK;
        op     = CELL_HOLD;
        at     = '0;
        case (t_req'(r_type))
            REQ_INS_FRONT: begin
                if (r_count == FULL) status = ST_FULL;
                else op = CELL_INSERT;
            end
            REQ_INS_END: begin
                if (r_count == FULL) begin
                    status = ST_FULL;
                end else begin
                    op = CELL_INSERT;
                    at = r_count;
                end
            end
            REQ_INS_POS: begin
                if (r_pos == 8'd0) begin
                    status = ST_INVALID;
                end else if (r_count == FULL) begin
                    status = ST_FULL;
                end else begin
                    op = CELL_INSERT;
                    at = (pos_m1 > cnt_w) ? r_count : pos_m1[CW-1:0];
                end
            end
            REQ_DEL_FRONT: begin
                if (r_count == '0) status = ST_EMPTY;
                else op = CELL_DELETE;
            end
            REQ_DEL_END: begin
                if (r_count == '0) begin
                    status = ST_EMPTY;
                end else begin
                    op = CELL_DELETE;
                    at = r_count - CW'(1);
                end
            end
            REQ_DEL_POS: begin
                if (r_count == '0) begin
                    status = ST_EMPTY;
                end else if (r_pos == 8'd0) begin
                    status = ST_INVALID;
                end else if (pos_w > cnt_w) begin
                    status = ST_BEYOND;
                end else begin
                    op = CELL_DELETE;
                    at = pos_m1[CW-1:0];
                end
            end
            default: status = ST_INVALID;
        endcase
    end

    // one-hot select of the entry being removed
    always_comb begin
        picked = '0;
        for (int k = 0; k < LIST_DEPTH; k++) begin
            if (at == CW'(k)) picked = picked | i_cell_word[k];
        end
    end

    always_comb begin
        n_count = r_count;
        if (exec && op == CELL_INSERT) n_count = r_count + CW'(1);
        if (exec && op == CELL_DELETE) n_count = r_count - CW'(1);
    end

    assign count_ext = {{COUNT_W{1'b0}}, n_count};

    assign o_cell_ctl.op   = exec ? op : CELL_HOLD;
    assign o_cell_ctl.word = r_word;
    assign o_at            = at;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_in_valid && o_in_ready) begin
                r_busy <= 1'b1;
            end else if (exec) begin
                r_busy <= 1'b0;
            end
            if (exec) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_type <= i_req_type;
            r_word <= i_item_value;
            r_pos  <= i_position;
        end
        if (exec) begin
            r_status  <= status;
            r_removed <= (op == CELL_DELETE) ? picked : '0;
            r_ecount  <= count_ext[COUNT_W-1:0];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_removed_value = r_removed;
    assign o_entry_count   = r_ecount;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("entry count above depth");

    a_ins_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec && op == CELL_INSERT |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not grow the list");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec && status == ST_FULL |=> o_out_valid && r_count == FULL)
        else $error("full status with room left");

    a_shift_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cell_ctl.op != CELL_HOLD |-> r_busy)
        else $error("chain shifted with no transaction held");

endmodule

`default_nettype wire

>>> hdl/positional_list_store.sv
// positional_list_store: bounded ordered list of signed 32-bit words.
// Instantiates pls_ctrl and a chain of LIST_DEPTH pls_cell; uses pls_pkg.
//
// Input channel (i_in_valid / o_in_ready) carries one request transaction:
// insert at front, end or 1-based position, or delete from front, end or
// position. Output channel (o_out_valid / i_out_ready) returns one result
// transaction per request: status, removed word (zero unless a delete
// succeeded) and the entry count after the request.
// Each request is taken into a holding register, then applied to the chain
// of cells: every cell loads its left neighbor, its right neighbor, the new
// word or itself. The result is registered when the request is applied,
// and no new request is taken until the held one has been applied. A
// result waiting on a stalled receiver does not block acceptance of the next
// request; that request waits in the holding register until the result
// register is taken. Reset (synchronous, active low) empties the list and
// drops any pending transaction; entry storage is not cleared.
`default_nettype none

module positional_list_store
    import pls_pkg::*;
#(
    parameter int LIST_DEPTH = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [2:0]           i_req_type,
    input  wire logic signed [31:0]   i_item_value,
    input  wire logic [7:0]           i_position,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [2:0]                o_status,
    output logic signed [31:0]        o_removed_value,
    output logic [4:0]                o_entry_count
);

    localparam int CW = $clog2(LIST_DEPTH + 1);

    logic [WORD_W-1:0] cell_word [LIST_DEPTH];
    t_cell_ctl         cell_ctl;
    logic [CW-1:0]     at;

    pls_ctrl #(
        .LIST_DEPTH(LIST_DEPTH),
        .CW        (CW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_item_value   (i_item_value),
        .i_position     (i_position),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_removed_value(o_removed_value),
        .o_entry_count  (o_entry_count),
        .i_cell_word    (cell_word),
        .o_cell_ctl     (cell_ctl),
        .o_at           (at)
    );

    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        logic [WORD_W-1:0] left;
        logic [WORD_W-1:0] right;

        if (g == 0) begin : g_first
            assign left = cell_ctl.word;
        end else begin : g_mid_l
            assign left = cell_word[g-1];
        end
        if (g == LIST_DEPTH - 1) begin : g_last
            assign right = cell_word[g];
        end else begin : g_mid_r
            assign right = cell_word[g+1];
        end

        pls_cell #(
            .IDX(g),
            .AW (CW)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctl  (cell_ctl),
            .i_at   (at),
            .i_left (left),
            .i_right(right),
            .o_word (cell_word[g])
        );
    end

endmodule

`default_nettype wire

>>> test/list_result_checker.sv
// list_result_checker: watches both channels of positional_list_store, keeps its own
// copy of the list to predict each result transaction and compares field by field.
// Depends on pls_pkg for the request and status codes.
module list_result_checker
    import pls_pkg::*;
#(
    parameter int LIST_DEPTH = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_ready,
    input  wire logic [2:0]         i_req_type,
    input  wire logic signed [31:0] i_item_value,
    input  wire logic [7:0]         i_position,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire logic [2:0]         i_status,
    input  wire logic signed [31:0] i_removed_value,
    input  wire logic [4:0]         i_entry_count,
    output int                      o_fail_count,
    output int                      o_pending
);

    typedef struct {
        logic [2:0]         status;
        logic signed [31:0] removed;
        logic [4:0]         count;
    } t_list_result;

    logic signed [31:0] shadow_list [LIST_DEPTH];
    int                 shadow_count;
    t_list_result       expected_results [$];

    task automatic insert_word(input int at, input logic signed [31:0] word,
                               output logic [2:0] status);
        int i;
        if (shadow_count >= LIST_DEPTH) begin
            status = ST_FULL;
        end else begin
            if (at > shadow_count) at = shadow_count;
            for (i = shadow_count; i > at; i--) shadow_list[i] = shadow_list[i - 1];
            shadow_list[at] = word;
            shadow_count++;
            status = ST_OK;
        end
    endtask

    task automatic remove_word(input int at, output logic signed [31:0] word);
        int i;
        word = shadow_list[at];
        for (i = at; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i + 1];
        shadow_count--;
    endtask

    task automatic predict_list_result(input logic [2:0] kind,
                                       input logic signed [31:0] word,
                                       input logic [7:0] pos,
                                       output t_list_result res);
        res.status  = ST_OK;
        res.removed = '0;
        case (kind)
            REQ_INS_FRONT: insert_word(0, word, res.status);
            REQ_INS_END:   insert_word(shadow_count, word, res.status);
            REQ_INS_POS: begin
                if (pos == 0) res.status = ST_INVALID;
                else insert_word(int'(pos) - 1, word, res.status);
            end
            REQ_DEL_FRONT: begin
                if (shadow_count == 0) res.status = ST_EMPTY;
                else remove_word(0, res.removed);
            end
            REQ_DEL_END: begin
                if (shadow_count == 0) res.status = ST_EMPTY;
                else remove_word(shadow_count - 1, res.removed);
            end
            REQ_DEL_POS: begin
                if (shadow_count == 0) res.status = ST_EMPTY;
                else if (pos == 0) res.status = ST_INVALID;
                else if (int'(pos) > shadow_count) res.status = ST_BEYOND;
                else remove_word(int'(pos) - 1, res.removed);
            end
            default: res.status = ST_INVALID;
        endcase
        res.count = shadow_count[4:0];
    endtask

    always @(posedge i_clk) begin
        t_list_result exp_res;
        t_list_result new_res;
        if (!i_rst_n) begin
            shadow_count = 0;
            expected_results.delete();
        end else begin
            // results pop before the new request pushes; latency keeps them apart
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with nothing expected");
                    o_fail_count++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (i_status !== exp_res.status) begin
                        $error("status expected %0d actual %0d", exp_res.status, i_status);
                        o_fail_count++;
                    end
                    if (i_removed_value !== exp_res.removed) begin
                        $error("removed_value expected %0d actual %0d",
                               exp_res.removed, i_removed_value);
                        o_fail_count++;
                    end
                    if (i_entry_count !== exp_res.count) begin
                        $error("entry_count expected %0d actual %0d",
                               exp_res.count, i_entry_count);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_list_result(i_req_type, i_item_value, i_position, new_res);
                expected_results.push_back(new_res);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

>>> test/tb_positional_list_store.sv
// tb_positional_list_store: drives request transactions into positional_list_store
// and random back-pressure on its results; list_result_checker does the checking.
// Depends on pls_pkg, positional_list_store and list_result_checker.
module tb_positional_list_store;
    import pls_pkg::*;

    localparam int LIST_DEPTH     = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 550;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [2:0]         i_req_type;
    logic signed [31:0] i_item_value;
    logic [7:0]         i_position;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [2:0]         o_status;
    logic signed [31:0] o_removed_value;
    logic [4:0]         o_entry_count;

    int   fail_count;
    int   pending;
    int   stall_cycles;
    logic idle_on;

    positional_list_store #(.LIST_DEPTH(LIST_DEPTH)) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_item_value   (i_item_value),
        .i_position     (i_position),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_removed_value(o_removed_value),
        .o_entry_count  (o_entry_count)
    );

    list_result_checker #(.LIST_DEPTH(LIST_DEPTH)) i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_item_value   (i_item_value),
        .i_position     (i_position),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_status       (o_status),
        .i_removed_value(o_removed_value),
        .i_entry_count  (o_entry_count),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) i_out_ready <= 1'b0;
        else i_out_ready <= !(idle_on && $urandom_range(0, 99) < 6);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_positional_list_store: errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic send_request(input t_req kind, input logic signed [31:0] word,
                                input logic [7:0] pos);
        while (idle_on && $urandom_range(0, 99) < 6) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= kind;
        i_item_value <= word;
        i_position   <= pos;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    initial begin
        int   n;
        int   r;
        int   mode;
        int   phase_left;
        logic ins;
        t_req kind;
        logic [7:0] pos;

        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_req_type = REQ_INS_FRONT;
        i_item_value = '0;
        i_position = '0;
        idle_on = 1'b1;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty list, invalid positions, extremes, append beyond length
        send_request(REQ_DEL_FRONT, 32'sd5, 8'd1);
        send_request(REQ_DEL_END, 32'sd5, 8'd1);
        send_request(REQ_DEL_POS, 32'sd5, 8'd0);
        send_request(REQ_INS_POS, 32'sd9, 8'd0);
        send_request(REQ_INS_FRONT, 32'sh7fffffff, 8'd0);
        send_request(REQ_INS_END, 32'sh80000000, 8'd255);
        send_request(REQ_INS_POS, 32'sh12345678, 8'd255);
        send_request(REQ_INS_POS, -32'sd1, 8'd1);
        send_request(REQ_INS_POS, 32'sd0, 8'd2);
        send_request(REQ_DEL_POS, 32'sd0, 8'd0);
        send_request(REQ_DEL_POS, 32'sd0, 8'd255);
        send_request(REQ_DEL_POS, 32'sd0, 8'd6);
        send_request(REQ_DEL_POS, 32'sd0, 8'd2);
        send_request(REQ_DEL_END, 32'sd0, 8'd0);
        send_request(REQ_DEL_FRONT, 32'sd0, 8'd0);
        send_request(REQ_DEL_FRONT, 32'sd0, 8'd0);
        send_request(REQ_DEL_END, 32'sd0, 8'd0);

        // fill past full, then an invalid position and a front insert on the full list
        for (n = 0; n < LIST_DEPTH + 1; n++) send_request(REQ_INS_END, $urandom, 8'd0);
        send_request(REQ_INS_POS, 32'sd7, 8'd0);
        send_request(REQ_INS_FRONT, 32'sd7, 8'd3);

        phase_left = 0;
        mode = 0;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                mode = $urandom_range(0, 2);
                phase_left = $urandom_range(10, 60);
            end
            phase_left--;
            idle_on = !(n >= 200 && n < 320);
            r = $urandom_range(0, 99);
            case (mode)
                0: ins = (r < 80);
                1: ins = (r < 20);
                default: ins = (r < 50);
            endcase
            kind = ins ? t_req'($urandom_range(REQ_INS_FRONT, REQ_INS_POS))
                       : t_req'($urandom_range(REQ_DEL_FRONT, REQ_DEL_POS));
            r = $urandom_range(0, 9);
            if (r < 7) pos = 8'($urandom_range(0, LIST_DEPTH + 1));
            else if (r < 9) pos = 8'($urandom_range(0, 3));
            else pos = 8'($urandom_range(0, 255));
            send_request(kind, $urandom, pos);
        end
        i_in_valid <= 1'b0;
        idle_on = 1'b1;

        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_positional_list_store: clean");
        end else begin
            $display("tb_positional_list_store: errors");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/pls_pkg.sv
hdl/pls_cell.sv
hdl/pls_ctrl.sv
hdl/positional_list_store.sv
test/list_result_checker.sv
test/tb_positional_list_store.sv
